>>> sv/psht_pkg.sv
// Shared types and constants for the point to segment hit test.
// No dependencies.
`timescale 1ns / 1ps
package psht_pkg;

   typedef enum logic [1:0] {
      SEG_START,
      SEG_END,
      SEG_INTERIOR
   } seg_kind_type;

   localparam int KIND_W      = 2;
   localparam int LINE_THR_W  = 24;
   localparam int EP_THR_W    = 40;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 40;

   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_THR = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EP_THR   = 2'd1;

   localparam logic [LINE_THR_W-1:0] LINE_THR_RESET = 24'd256;
   localparam logic [EP_THR_W-1:0]   EP_THR_RESET   = 40'd409600;

   localparam logic [1:0] HIT_NONE  = 2'd0;
   localparam logic [1:0] HIT_START = 2'd1;
   localparam logic [1:0] HIT_END   = 2'd2;

endpackage

>>> sv/psht_front.sv
// Front part: differences, dot products, classification and endpoint tests.
// Depends on psht_pkg.
`timescale 1ns / 1ps
module psht_front #(
   parameter int CW = 24,
   parameter int DW = 2 * CW + 3,
   parameter int QW = 5 + 2 * DW + 4 * (CW + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [CW-1:0]            qx,
   input  logic signed [CW-1:0]            qy,
   input  logic signed [CW-1:0]            sx,
   input  logic signed [CW-1:0]            sy,
   input  logic signed [CW-1:0]            ex,
   input  logic signed [CW-1:0]            ey,
   input  logic [psht_pkg::EP_THR_W-1:0]   ep_thr,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [QW-1:0]                   out_data
);

   localparam int SQW = 2 * CW + 3;
   localparam int CMPW = (SQW > psht_pkg::EP_THR_W) ? SQW : psht_pkg::EP_THR_W;

   logic enable;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [CW:0]   dx1_ff, dy1_ff, px1_ff, py1_ff, ex1_ff, ey1_ff;
   logic signed [CW:0]   dx2_ff, dy2_ff, px2_ff, py2_ff, ex2_ff, ey2_ff;
   logic signed [2*CW+1:0] pxdx_ff, pydy_ff, dxdx_ff, dydy_ff;
   logic signed [2*CW+1:0] pxpx_ff, pypy_ff, exex_ff, eyey_ff;
   logic signed [CW:0]   dx3_ff, dy3_ff, px3_ff, py3_ff, ex3_ff, ey3_ff;
   logic signed [DW-1:0] num3_ff, den3_ff;
   logic [SQW-1:0]       sqp3_ff, sqe3_ff;
   logic [QW-1:0]        data4_ff, data4_in;

   psht_pkg::seg_kind_type kind;
   logic                 start_hit, end_hit, degen;
   logic signed [CW:0]   rbx, rby;

   assign enable    = !(v4_ff && !out_ready);
   assign in_ready  = enable;
   assign out_valid = v4_ff;
   assign out_data  = data4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx1_ff <= {ex[CW-1], ex} - {sx[CW-1], sx};
         dy1_ff <= {ey[CW-1], ey} - {sy[CW-1], sy};
         px1_ff <= {qx[CW-1], qx} - {sx[CW-1], sx};
         py1_ff <= {qy[CW-1], qy} - {sy[CW-1], sy};
         ex1_ff <= {qx[CW-1], qx} - {ex[CW-1], ex};
         ey1_ff <= {qy[CW-1], qy} - {ey[CW-1], ey};

         pxdx_ff <= px1_ff * dx1_ff;
         pydy_ff <= py1_ff * dy1_ff;
         dxdx_ff <= dx1_ff * dx1_ff;
         dydy_ff <= dy1_ff * dy1_ff;
         pxpx_ff <= px1_ff * px1_ff;
         pypy_ff <= py1_ff * py1_ff;
         exex_ff <= ex1_ff * ex1_ff;
         eyey_ff <= ey1_ff * ey1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         ex2_ff <= ex1_ff;
         ey2_ff <= ey1_ff;

         num3_ff <= DW'(pxdx_ff) + DW'(pydy_ff);
         den3_ff <= DW'(dxdx_ff) + DW'(dydy_ff);
         sqp3_ff <= {1'b0, pxpx_ff} + {1'b0, pypy_ff};
         sqe3_ff <= {1'b0, exex_ff} + {1'b0, eyey_ff};
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         ex3_ff <= ex2_ff;
         ey3_ff <= ey2_ff;

         data4_ff <= data4_in;
      end
   end

   always_comb begin
      degen     = (dx3_ff == '0) && (dy3_ff == '0);
      start_hit = CMPW'(sqp3_ff) < CMPW'(ep_thr);
      end_hit   = CMPW'(sqe3_ff) < CMPW'(ep_thr);
      priority if (num3_ff <= 0) begin
         kind = psht_pkg::SEG_START;
      end else if (num3_ff >= den3_ff) begin
         kind = psht_pkg::SEG_END;
      end else begin
         kind = psht_pkg::SEG_INTERIOR;
      end
      if (kind == psht_pkg::SEG_END) begin
         rbx = ex3_ff;
         rby = ey3_ff;
      end else begin
         rbx = px3_ff;
         rby = py3_ff;
      end
      data4_in = {kind, start_hit, end_hit, degen, num3_ff, den3_ff,
                  dx3_ff, dy3_ff, rbx, rby};
   end

endmodule

>>> sv/psht_queue.sv
// Short queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
module psht_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != (AW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue count above depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");
   a_empty_no_pop: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule

>>> sv/psht_back.sv
// Back part: projection divider, residual, square sum, square root, hit decision.
// Depends on psht_pkg.
`timescale 1ns / 1ps
module psht_back #(
   parameter int CW  = 24,
   parameter int PFB = 16,
   parameter int DW  = 2 * CW + 3,
   parameter int QW  = 5 + 2 * DW + 4 * (CW + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [QW-1:0]                   in_data,
   input  logic [psht_pkg::LINE_THR_W-1:0] line_thr,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [CW:0]                     out_distance,
   output logic                            out_near,
   output logic [1:0]                      out_hit,
   output logic                            out_degen
);

   localparam int RW  = CW + 2;
   localparam int SQW = 2 * RW;
   localparam int NR  = RW;
   localparam int PW  = PFB + CW + 2;
   localparam int NCW = (SQW > psht_pkg::LINE_THR_W) ? SQW : psht_pkg::LINE_THR_W;

   logic enable, pop;

   logic [psht_pkg::KIND_W-1:0] q_kind;
   logic                 q_sh, q_eh, q_dg;
   logic signed [DW-1:0] q_num, q_den;
   logic signed [CW:0]   q_dx, q_dy, q_rbx, q_rby;

   assign {q_kind, q_sh, q_eh, q_dg, q_num, q_den, q_dx, q_dy, q_rbx, q_rby} = in_data;

   assign enable   = !(out_valid && !out_ready);
   assign pop      = enable && in_valid;
   assign in_ready = enable;

   // divider stages
   logic                 dv_ff   [PFB+1];
   logic [1:0]           dk_ff   [PFB+1];
   logic [2:0]           df_ff   [PFB+1];
   logic [DW-1:0]        dden_ff [PFB+1];
   logic [DW-1:0]        dr_ff   [PFB+1];
   logic [PFB-1:0]       dt_ff   [PFB+1];
   logic signed [CW:0]   ddx_ff  [PFB+1];
   logic signed [CW:0]   ddy_ff  [PFB+1];
   logic signed [CW:0]   drx_ff  [PFB+1];
   logic signed [CW:0]   dry_ff  [PFB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (enable) begin
         dv_ff[0] <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dk_ff[0]   <= q_kind;
         df_ff[0]   <= {q_sh, q_eh, q_dg};
         dden_ff[0] <= q_den;
         dr_ff[0]   <= (psht_pkg::seg_kind_type'(q_kind) == psht_pkg::SEG_INTERIOR) ?
                       q_num : '0;
         dt_ff[0]   <= '0;
         ddx_ff[0]  <= q_dx;
         ddy_ff[0]  <= q_dy;
         drx_ff[0]  <= q_rbx;
         dry_ff[0]  <= q_rby;
      end
   end

   for (genvar k = 0; k < PFB; k++) begin : g_div
      logic [DW:0] r2, diff;
      logic        take;
      assign r2   = {dr_ff[k], 1'b0};
      assign diff = r2 - {1'b0, dden_ff[k]};
      assign take = r2 >= {1'b0, dden_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (enable) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dk_ff[k+1]   <= dk_ff[k];
            df_ff[k+1]   <= df_ff[k];
            dden_ff[k+1] <= dden_ff[k];
            dr_ff[k+1]   <= take ? diff[DW-1:0] : r2[DW-1:0];
            dt_ff[k+1]   <= {dt_ff[k][PFB-2:0], take};
            ddx_ff[k+1]  <= ddx_ff[k];
            ddy_ff[k+1]  <= ddy_ff[k];
            drx_ff[k+1]  <= drx_ff[k];
            dry_ff[k+1]  <= dry_ff[k];
         end
      end
   end

   // scale, residual, squares, sum
   logic                mv_ff, rv_ff, sv_ff, uv_ff;
   logic [1:0]          mk_ff;
   logic [2:0]          mf_ff, rf_ff, sf_ff, uf_ff;
   logic signed [PW-1:0] mpx_ff, mpy_ff;
   logic signed [CW:0]  mrx_ff, mry_ff;
   logic signed [RW-1:0] rx_ff, ry_ff, rx_in, ry_in;
   logic [SQW-1:0]      sqx_ff, sqy_ff, sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         rv_ff <= 1'b0;
         sv_ff <= 1'b0;
         uv_ff <= 1'b0;
      end else if (enable) begin
         mv_ff <= dv_ff[PFB];
         rv_ff <= mv_ff;
         sv_ff <= rv_ff;
         uv_ff <= sv_ff;
      end
   end

   always_comb begin
      rx_in = {mrx_ff[CW], mrx_ff};
      ry_in = {mry_ff[CW], mry_ff};
      if (psht_pkg::seg_kind_type'(mk_ff) == psht_pkg::SEG_INTERIOR) begin
         rx_in = rx_in - mpx_ff[PFB+RW-1:PFB];
         ry_in = ry_in - mpy_ff[PFB+RW-1:PFB];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mk_ff  <= dk_ff[PFB];
         mf_ff  <= df_ff[PFB];
         mpx_ff <= $signed({1'b0, dt_ff[PFB]}) * ddx_ff[PFB];
         mpy_ff <= $signed({1'b0, dt_ff[PFB]}) * ddy_ff[PFB];
         mrx_ff <= drx_ff[PFB];
         mry_ff <= dry_ff[PFB];

         rf_ff <= mf_ff;
         rx_ff <= rx_in;
         ry_ff <= ry_in;

         sf_ff  <= rf_ff;
         sqx_ff <= SQW'($signed(rx_ff) * $signed(rx_ff));
         sqy_ff <= SQW'($signed(ry_ff) * $signed(ry_ff));

         uf_ff  <= sf_ff;
         sum_ff <= sqx_ff + sqy_ff;
      end
   end

   // square root, one result bit per stage
   logic           qv_ff  [NR+1];
   logic [2:0]     qf_ff  [NR+1];
   logic [SQW-1:0] qrem_ff[NR+1];
   logic [SQW-1:0] qres_ff[NR+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff[0] <= 1'b0;
      end else if (enable) begin
         qv_ff[0] <= uv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         qf_ff[0]   <= uf_ff;
         qrem_ff[0] <= sum_ff;
         qres_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < NR; j++) begin : g_sqrt
      localparam logic [SQW:0] BIT = (SQW+1)'(1) << (2 * (NR - 1 - j));
      logic [SQW:0] trial;
      logic         fit;
      assign trial = {1'b0, qres_ff[j]} + BIT;
      assign fit   = {1'b0, qrem_ff[j]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[j+1] <= 1'b0;
         end else if (enable) begin
            qv_ff[j+1] <= qv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            qf_ff[j+1] <= qf_ff[j];
            if (fit) begin
               qrem_ff[j+1] <= qrem_ff[j] - trial[SQW-1:0];
               qres_ff[j+1] <= (qres_ff[j] >> 1) + BIT[SQW-1:0];
            end else begin
               qrem_ff[j+1] <= qrem_ff[j];
               qres_ff[j+1] <= qres_ff[j] >> 1;
            end
         end
      end
   end

   // result register
   logic        ov_ff, on_ff, od_ff, near_in;
   logic [CW:0] odist_ff;
   logic [1:0]  oh_ff, hit_in;

   always_comb begin
      near_in = NCW'(qres_ff[NR]) < NCW'(line_thr);
      priority if (near_in && qf_ff[NR][2]) begin
         hit_in = psht_pkg::HIT_START;
      end else if (near_in && qf_ff[NR][1]) begin
         hit_in = psht_pkg::HIT_END;
      end else begin
         hit_in = psht_pkg::HIT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (enable) begin
         ov_ff <= qv_ff[NR];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         odist_ff <= qres_ff[NR][CW:0];
         on_ff    <= near_in;
         oh_ff    <= hit_in;
         od_ff    <= qf_ff[NR][0];
      end
   end

   assign out_valid    = ov_ff;
   assign out_distance = odist_ff;
   assign out_near     = on_ff;
   assign out_hit      = oh_ff;
   assign out_degen    = od_ff;

`ifndef SYNTHESIS
   a_hit_needs_near: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_hit != psht_pkg::HIT_NONE) |-> out_near)
      else $error("endpoint hit without near line");
   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_hit == psht_pkg::HIT_NONE || out_hit == psht_pkg::HIT_START ||
                     out_hit == psht_pkg::HIT_END))
      else $error("bad endpoint hit code");
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      qv_ff[NR] |-> qrem_ff[NR] <= {qres_ff[NR][SQW-2:0], 1'b0})
      else $error("square root remainder too large");
`endif

endmodule

>>> sv/point_segment_hit_test.sv
// From input transfer to result the path runs through 4 front stages, a queue,
// PROJ_FRAC_BITS divider steps and COORD_WIDTH+2 root steps.
// Throughput: one item per cycle while no stage holds; the back pipeline holds only while a
// result waits and the front while the queue is full. Reset (synchronous, active high)
// empties all stages and the queue and loads the thresholds with 1.0 and 2.5 squared.
`timescale 1ns / 1ps
module point_segment_hit_test #(
   parameter int COORD_WIDTH    = 24,
   parameter int PROJ_FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // query_x, query_y, start_x, start_y, end_x, end_y
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // distance, near_line, endpoint_hit, degenerate
   output logic [((COORD_WIDTH+5+7)/8)*8-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [psht_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [psht_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = 2 * CW + 3;
   localparam int QW  = 5 + 2 * DW + 4 * (CW + 1);
   localparam int OW  = ((CW + 5 + 7) / 8) * 8;

   logic [psht_pkg::LINE_THR_W-1:0] line_thr_ff;
   logic [psht_pkg::EP_THR_W-1:0]   ep_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_thr_ff <= psht_pkg::LINE_THR_RESET;
         ep_thr_ff   <= psht_pkg::EP_THR_RESET;
      end else if (csr_we) begin
         if (csr_addr == psht_pkg::CSR_LINE_THR) begin
            line_thr_ff <= csr_wdata[psht_pkg::LINE_THR_W-1:0];
         end
         if (csr_addr == psht_pkg::CSR_EP_THR) begin
            ep_thr_ff <= csr_wdata[psht_pkg::EP_THR_W-1:0];
         end
      end
   end

   logic          f_valid, f_ready, b_valid, b_ready;
   logic [QW-1:0] f_data, b_data;
   logic [CW:0]   distance;
   logic          near_line, degenerate;
   logic [1:0]    endpoint_hit;

   psht_front #(.CW(CW), .DW(DW), .QW(QW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .qx       (req_tdata[0*CW +: CW]),
      .qy       (req_tdata[1*CW +: CW]),
      .sx       (req_tdata[2*CW +: CW]),
      .sy       (req_tdata[3*CW +: CW]),
      .ex       (req_tdata[4*CW +: CW]),
      .ey       (req_tdata[5*CW +: CW]),
      .ep_thr   (ep_thr_ff),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .out_data (f_data)
   );

   psht_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_data),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_data  (b_data)
   );

   psht_back #(.CW(CW), .PFB(PROJ_FRAC_BITS), .DW(DW), .QW(QW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid),
      .in_ready    (b_ready),
      .in_data     (b_data),
      .line_thr    (line_thr_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_distance(distance),
      .out_near    (near_line),
      .out_hit     (endpoint_hit),
      .out_degen   (degenerate)
   );

   assign rsp_tdata = OW'({degenerate, endpoint_hit, near_line, distance});

endmodule
